// ===== design/worst_fit_hole_allocator_top_macros.svh =====
// Assertion macros shared by the allocator checker.
// Needs nothing else; pulled in by `include where assertions are written.
`ifndef WORST_FIT_HOLE_ALLOCATOR_TOP_MACROS_SVH
`define WORST_FIT_HOLE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WFHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define WFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== design/wfha_pkg.sv =====
// Package for the worst-fit hole allocator: item types and status codes.
// No dependencies; used by the allocator top level, the checker and the bench.
`default_nettype none

package wfha_pkg;

  // Input item
  typedef struct packed {
    logic        func;
    logic [15:0] size;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  hole_index;
    logic [15:0] leftover;
    logic [19:0] total_leftover;
  } out_item_t;

  // Operation codes
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // Status codes
  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_ALLOCATED = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int          FIELD_BITS = 16;
  localparam logic [19:0] SUM_MAX    = 20'hFFFFF;

endpackage

`default_nettype wire

// ===== design/wfha_table.sv =====
// Hole table: size memory with registered read, and available flags.
// Depends on nothing; instantiated by worst_fit_hole_allocator_top.
`default_nettype none

module wfha_table #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int SW    = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire logic [SW-1:0] wr_data,
  input  wire logic          clr_en,
  input  wire logic [IW-1:0] clr_addr,
  input  wire logic [IW-1:0] rd_addr,
  output      logic [SW-1:0] rd_size,
  output      logic          rd_avail
);

  logic [SW-1:0] sizes [DEPTH];
  logic [DEPTH-1:0] avail;

  // Size memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sizes[wr_addr] <= wr_data;
    end
    rd_size <= sizes[rd_addr];
  end

  // Available flags: set on load, cleared on grant
  always_ff @(posedge clk) begin
    if (rst) begin
      avail    <= '0;
      rd_avail <= 1'b0;
    end else begin
      if (wr_en) begin
        avail[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        avail[clr_addr] <= 1'b0;
      end
      rd_avail <= avail[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/wfha_best.sv =====
// Shared compare unit: keeps the largest available hole seen in a scan.
// Depends on nothing; instantiated by worst_fit_hole_allocator_top.
`default_nettype none

module wfha_best #(
  parameter int IW = 4,
  parameter int SW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic          en,
  input  wire logic          cand_avail,
  input  wire logic [SW-1:0] cand_size,
  input  wire logic [IW-1:0] cand_idx,
  output      logic          found,
  output      logic [SW-1:0] best_size,
  output      logic [IW-1:0] best_idx
);

  logic take;

  // Strict greater keeps the lowest index on ties
  assign take = en && cand_avail && (!found || (cand_size > best_size));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best_size <= cand_size;
      best_idx  <= cand_idx;
    end
  end

endmodule

`default_nettype wire

// ===== design/worst_fit_hole_allocator_top.sv =====
// Worst-fit hole allocator top level: sequencer, counters, result register.
// Depends on wfha_pkg, wfha_table and wfha_best.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------
//   input   | req_valid | req_stall | req_item (func, size)
//   output  | rsp_valid | rsp_stall | rsp_item (4 result fields)
//
// A load passes from the idle state to the result state. A request passes
// through the scan, drain and decide states first, or goes straight to the
// result state on an empty table. In the scan, one compare unit visits one
// table entry per cycle behind the registered memory read. req_stall is high
// from accept until the result moves into the output register; a result still
// held there by rsp_stall delays that move. Reset clears flags and counters.
`default_nettype none

module worst_fit_hole_allocator_top #(
  parameter int MAX_HOLES = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output      logic                req_stall,
  input  wire wfha_pkg::in_item_t  req_item,
  output      logic                rsp_valid,
  input  wire logic                rsp_stall,
  output      wfha_pkg::out_item_t rsp_item
);

  localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam int SW = (SIZE_BITS < wfha_pkg::FIELD_BITS) ? SIZE_BITS
                                                         : wfha_pkg::FIELD_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_HOLES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_RESULT
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [19:0]         sum;
  logic [SW-1:0]       req_size;
  logic [IW-1:0]       scan_idx;
  logic                cand_vld;
  logic [IW-1:0]       cand_idx;
  wfha_pkg::out_item_t res;

  logic          accept;
  logic          is_load;
  logic          is_full;
  logic [SW-1:0] in_size;
  logic          wr_en;
  logic          clr_en;
  logic          grant;
  logic          last_issue;
  logic          out_free;
  logic          rsp_load;
  logic [SW-1:0] rd_size;
  logic          rd_avail;
  logic          found;
  logic [SW-1:0] best_size;
  logic [IW-1:0] best_idx;
  logic [SW-1:0] left;
  logic [20:0]   sum_wide;
  logic [19:0]   sum_next;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign is_load    = (req_item.func == wfha_pkg::FUNC_LOAD);
  assign is_full    = (count == FULL_COUNT);
  assign in_size    = req_item.size[SW-1:0];
  assign wr_en      = accept && is_load && !is_full;
  assign last_issue = (CW'(scan_idx) == (count - CW'(1)));
  assign out_free   = !rsp_valid || !rsp_stall;
  assign rsp_load   = (state == S_RESULT) && out_free;

  // Grant decision and saturating running total
  assign grant    = found && (best_size >= req_size);
  assign left     = best_size - req_size;
  assign sum_wide = {1'b0, sum} + 21'(left);
  assign sum_next = (sum_wide > {1'b0, wfha_pkg::SUM_MAX}) ? wfha_pkg::SUM_MAX
                                                           : sum_wide[19:0];
  assign clr_en   = (state == S_DECIDE) && grant;

  wfha_table #(
    .DEPTH (MAX_HOLES),
    .IW    (IW),
    .SW    (SW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (count[IW-1:0]),
    .wr_data  (in_size),
    .clr_en   (clr_en),
    .clr_addr (best_idx),
    .rd_addr  (scan_idx),
    .rd_size  (rd_size),
    .rd_avail (rd_avail)
  );

  wfha_best #(
    .IW (IW),
    .SW (SW)
  ) u_best (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .en         (cand_vld),
    .cand_avail (rd_avail),
    .cand_size  (rd_size),
    .cand_idx   (cand_idx),
    .found      (found),
    .best_size  (best_size),
    .best_idx   (best_idx)
  );

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum       <= '0;
      scan_idx  <= '0;
      cand_vld  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cand_vld <= (state == S_SCAN);
      cand_idx <= scan_idx;
      // Output register: load a finished result, or empty once taken
      if (rsp_load) begin
        rsp_item  <= res;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res.total_leftover <= sum;
            res.leftover       <= '0;
            if (is_load) begin
              if (is_full) begin
                res.status     <= wfha_pkg::ST_FULL;
                res.hole_index <= '0;
              end else begin
                res.status     <= wfha_pkg::ST_LOADED;
                res.hole_index <= 4'(count);
                count          <= count + CW'(1);
              end
              state <= S_RESULT;
            end else begin
              req_size       <= in_size;
              scan_idx       <= '0;
              res.status     <= wfha_pkg::ST_NOT_ALLOC;
              res.hole_index <= '0;
              if (count == '0) begin
                state <= S_RESULT;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (last_issue) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (grant) begin
            res.status         <= wfha_pkg::ST_ALLOCATED;
            res.hole_index     <= 4'(best_idx);
            res.leftover       <= 16'(left);
            res.total_leftover <= sum_next;
            sum                <= sum_next;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/wfha_checker.sv =====
// Port-level checker for the worst-fit hole allocator, with its bind.
// Depends on wfha_pkg and worst_fit_hole_allocator_top_macros.svh.
`default_nettype none

`include "worst_fit_hole_allocator_top_macros.svh"

module wfha_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_stall,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire wfha_pkg::out_item_t rsp_item
);

  // A pending result is not dropped while stalled
  `WFHA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)

  // The block is busy right after it takes an item
  `WFHA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)

  // Only a grant reports leftover space
  `WFHA_ASSERT_IMP(a_leftover_grant_only, clk, rst,
    rsp_valid && (rsp_item.status != wfha_pkg::ST_ALLOCATED), rsp_item.leftover == 16'd0)

  // Refused items report index zero
  `WFHA_ASSERT_IMP(a_index_zero_refused, clk, rst,
    rsp_valid && (rsp_item.status == wfha_pkg::ST_NOT_ALLOC ||
                  rsp_item.status == wfha_pkg::ST_FULL), rsp_item.hole_index == 4'd0)

endmodule

bind worst_fit_hole_allocator_top wfha_checker u_wfha_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for worst_fit_hole_allocator_top: directed and random items with a
// cycle-free predictor of the hole table. Needs wfha_pkg and the allocator RTL only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLE_SLOTS  = 16;
  localparam int DRAIN_TICKS = HOLE_SLOTS + 24;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  wfha_pkg::in_item_t  req_item;
  logic                rsp_valid;
  logic                rsp_stall;
  wfha_pkg::out_item_t rsp_item;

  // Predictor state: the hole table as the block should hold it
  logic [15:0]           hole_len [HOLE_SLOTS];
  logic [HOLE_SLOTS-1:0] hole_open;
  int                    holes_loaded;
  logic [19:0]           waste_sum;

  wfha_pkg::out_item_t pending_results[$];
  int                  err_count;
  bit                  tx_idle;
  bit                  rx_idle;
  int                  rx_hold_cycles;

  worst_fit_hole_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the result of one accepted item and updates the table copy
  function automatic wfha_pkg::out_item_t predict_allocation(wfha_pkg::in_item_t it);
    wfha_pkg::out_item_t r;
    int                  best;
    logic                found;
    logic [20:0]         sum;
    r     = '0;
    found = 1'b0;
    best  = 0;
    if (it.func == wfha_pkg::FUNC_LOAD) begin
      if (holes_loaded >= HOLE_SLOTS) begin
        r.status = wfha_pkg::ST_FULL;
      end else begin
        hole_len[holes_loaded]  = it.size;
        hole_open[holes_loaded] = 1'b1;
        r.status     = wfha_pkg::ST_LOADED;
        r.hole_index = 4'(holes_loaded);
        holes_loaded++;
      end
    end else begin
      // largest open hole, lowest index on ties
      for (int k = 0; k < holes_loaded; k++) begin
        if (hole_open[k] && (!found || hole_len[k] > hole_len[best])) begin
          found = 1'b1;
          best  = k;
        end
      end
      if (!found || hole_len[best] < it.size) begin
        r.status = wfha_pkg::ST_NOT_ALLOC;
      end else begin
        hole_open[best] = 1'b0;
        r.status     = wfha_pkg::ST_ALLOCATED;
        r.hole_index = 4'(best);
        r.leftover   = hole_len[best] - it.size;
        sum          = 21'(waste_sum) + 21'(r.leftover);
        waste_sum    = (sum > 21'(wfha_pkg::SUM_MAX)) ? wfha_pkg::SUM_MAX : sum[19:0];
      end
    end
    r.total_leftover = waste_sum;
    return r;
  endfunction

  function automatic wfha_pkg::in_item_t random_item(int load_pct);
    wfha_pkg::in_item_t it;
    it.func = ($urandom_range(0, 99) < load_pct) ? wfha_pkg::FUNC_LOAD
                                                 : wfha_pkg::FUNC_REQUEST;
    case ($urandom_range(0, 3))
      0: it.size = 16'($urandom);
      1: it.size = 16'($urandom_range(0, 255));
      2: it.size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: it.size = 16'($urandom) >> $urandom_range(1, 15);
    endcase
    return it;
  endfunction

  // Offers one item from a falling edge and returns at the edge that takes it
  task automatic send_item(input logic func, input logic [15:0] size);
    wfha_pkg::in_item_t it;
    int                 gap;
    it.func = func;
    it.size = size;
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_allocation(it));
  endtask

  task automatic quiet_sender();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    quiet_sender();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Requests on an empty table: no hole free
  task automatic test_empty_requests();
    send_item(wfha_pkg::FUNC_REQUEST, 16'h0000);
    send_item(wfha_pkg::FUNC_REQUEST, 16'hFFFF);
  endtask

  // A few holes: ties, a zero hole, a full-size hole, too-small and zero requests
  task automatic test_grant_rules();
    send_item(wfha_pkg::FUNC_LOAD, 16'd100);
    send_item(wfha_pkg::FUNC_LOAD, 16'd100);
    send_item(wfha_pkg::FUNC_LOAD, 16'h0000);
    send_item(wfha_pkg::FUNC_LOAD, 16'hFFFF);
    send_item(wfha_pkg::FUNC_REQUEST, 16'hFFFF);
    send_item(wfha_pkg::FUNC_REQUEST, 16'd50);
    send_item(wfha_pkg::FUNC_REQUEST, 16'd101);
    send_item(wfha_pkg::FUNC_REQUEST, 16'h0000);
    send_item(wfha_pkg::FUNC_REQUEST, 16'h0000);
    send_item(wfha_pkg::FUNC_REQUEST, 16'h0000);
  endtask

  // Random mix of loads and requests, 30 percent loads
  task automatic test_random_fill();
    wfha_pkg::in_item_t it;
    for (int n = 0; n < 80; n++) begin
      it = random_item(30);
      send_item(it.func, it.size);
    end
  endtask

  // Fill every slot, load into a full table, then grant every open hole
  task automatic test_table_full();
    while (holes_loaded < HOLE_SLOTS) send_item(wfha_pkg::FUNC_LOAD, 16'($urandom));
    send_item(wfha_pkg::FUNC_LOAD, 16'hFFFF);
    send_item(wfha_pkg::FUNC_LOAD, 16'h0000);
    while (|hole_open) send_item(wfha_pkg::FUNC_REQUEST, 16'h0000);
    send_item(wfha_pkg::FUNC_REQUEST, 16'h0000);
  endtask

  // Receiver holds off long while items keep coming, so the input backs up
  task automatic test_backpressure();
    wfha_pkg::in_item_t it;
    rx_hold_cycles = 400;
    tx_idle        = 1'b0;
    for (int n = 0; n < 40; n++) begin
      it = random_item(50);
      send_item(it.func, it.size);
    end
    tx_idle = 1'b1;
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    wfha_pkg::in_item_t it;
    wait_all_results();
    for (int n = 0; n < 10; n++) begin
      it = random_item(50);
      send_item(it.func, it.size);
    end
  endtask

  // Long random run with idling switched per block, ending with none
  task automatic test_random_tail();
    wfha_pkg::in_item_t it;
    for (int blk = 0; blk < 12; blk++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 100; n++) begin
        it = random_item(50);
        send_item(it.func, it.size);
      end
    end
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int n = 0; n < 180; n++) begin
      it = random_item(50);
      send_item(it.func, it.size);
    end
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req_item       = '0;
    hole_open      = '0;
    holes_loaded   = 0;
    waste_sum      = '0;
    err_count      = 0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    rx_hold_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_requests();
    test_grant_rules();
    test_random_fill();
    test_table_full();
    test_backpressure();
    test_drain_pause();
    test_random_tail();

    wait_all_results();
    repeat (DRAIN_TICKS) @(posedge clk);
    if (err_count == 0) begin
      $display("** worst_fit_hole_allocator_top: PASSED **");
    end else begin
      $display("** worst_fit_hole_allocator_top: FAILED **");
    end
    $finish;
  end

  // Result side stall: random bursts, plus long hold-offs on request
  initial begin
    int burst_left;
    burst_left = 0;
    rsp_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        rx_hold_cycles--;
      end else if (burst_left > 0) begin
        rsp_stall <= 1'b1;
        burst_left--;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        rsp_stall  <= 1'b1;
        burst_left = $urandom_range(1, 13) - 1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Compares each taken result with the oldest expectation
  initial begin
    wfha_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_item);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_item.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     rsp_item.status);
            err_count++;
          end
          if (rsp_item.hole_index !== want.hole_index) begin
            $display("%0t: hole_index expected %0d got %0d", $time, want.hole_index,
                     rsp_item.hole_index);
            err_count++;
          end
          if (rsp_item.leftover !== want.leftover) begin
            $display("%0t: leftover expected %0d got %0d", $time, want.leftover,
                     rsp_item.leftover);
            err_count++;
          end
          if (rsp_item.total_leftover !== want.total_leftover) begin
            $display("%0t: total_leftover expected %0d got %0d", $time,
                     want.total_leftover, rsp_item.total_leftover);
            err_count++;
          end
        end
      end
    end
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("** worst_fit_hole_allocator_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== worst_fit_hole_allocator_top.f =====
+incdir+design
design/wfha_pkg.sv
design/wfha_table.sv
design/wfha_best.sv
design/worst_fit_hole_allocator_top.sv
design/wfha_checker.sv
tb/tb.sv
